FILE: hw/rtl/mswpg_pkg.sv
// shared constants and helpers for the multiscale window position generator
`timescale 1ns / 1ps
`default_nettype none

package mswpg_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int COORD_BITS  = 16;
    localparam int FACTOR_BITS = 20;
    localparam int DIM_BITS    = 13;
    localparam int STRIDE_BITS = 8;
    localparam int COUNT_BITS  = 7;
    localparam int INDEX_BITS  = 6;
    localparam int SAMPLE_BITS = 32;
    localparam int DIV_BITS    = 32;
    localparam int PROD_BITS   = DIV_BITS + DIM_BITS;
    localparam int CFG_IDX_BITS = 3;

    localparam logic [FACTOR_BITS-1:0] FACTOR_CEIL = FACTOR_BITS'(10 << FRAC_BITS);
    localparam logic [COUNT_BITS-1:0]  MAX_SCALES = COUNT_BITS'(64);

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_WIDTH   = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_HEIGHT  = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_STRIDE        = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_SCALE_COUNT   = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_SPACING_MODE  = 3'd6;

    // quotient clipped to the largest scale factor
    function automatic logic [FACTOR_BITS-1:0] sat_factor(input logic [DIV_BITS-1:0] q);
        if (q > DIV_BITS'(FACTOR_CEIL)) begin
            return FACTOR_CEIL;
        end
        return q[FACTOR_BITS-1:0];
    endfunction

    // factor * dim >> FRAC_BITS, clipped to the coordinate range
    function automatic logic [COORD_BITS-1:0] sat_coord(input logic [PROD_BITS-1:0] p);
        if (p[PROD_BITS-1:FRAC_BITS+COORD_BITS] != '0) begin
            return '1;
        end
        return p[FRAC_BITS+COORD_BITS-1:FRAC_BITS];
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/multiscale_window_position_generator.sv
// Multiscale window position generator: image pyramid sliding-window scan.
// Each transfer on the s_ channel requests one window position; s_restart set
// starts over at the first scale. Exactly one result transfer follows on the m_
// channel for every request. m_valid_res clear means the scan is exhausted.
// Configuration is written on the cfg_ channel (always ready); the user must
// write it only while idle, as the block itself does not enforce this.
// A request inside a scale passes through the step and emit states before
// m_valid rises, and the sequencer then returns to idle for the next request.
// A request that starts the scan first runs two divisions for the minimum
// factor, then the scale search. Each scale tried uses the one shared
// 32-step restoring divider and the shared 32x13 multiplier.
// s_ready is high only while the sequencer is idle; one request is in work
// at a time. A finished result waits in the output register while the next
// request is accepted; if the receiver stalls with both a result waiting and
// a new one done, the sequencer holds until the output register frees.
// Reset (aresetn low, synchronous) loads the register defaults and leaves the
// scan pending, so the first request starts the scan whatever s_restart is.
`timescale 1ns / 1ps
`default_nettype none

module multiscale_window_position_generator (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   s_valid,
    output logic                                        s_ready,
    input  wire logic                                   s_restart,
    output logic                                        m_valid,
    input  wire logic                                   m_ready,
    output logic                                        m_valid_res,
    output logic [mswpg_pkg::INDEX_BITS-1:0]            m_scale_index,
    output logic [mswpg_pkg::FACTOR_BITS-1:0]           m_scale_factor,
    output logic [mswpg_pkg::COORD_BITS-1:0]            m_pos_x,
    output logic [mswpg_pkg::COORD_BITS-1:0]            m_pos_y,
    output logic [mswpg_pkg::SAMPLE_BITS-1:0]           m_sample_index,
    output logic                                        m_last_in_scale,
    output logic                                        m_last_overall,
    input  wire logic                                   cfg_valid,
    output logic                                        cfg_ready,
    input  wire logic [mswpg_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  wire logic [mswpg_pkg::DIM_BITS-1:0]         cfg_data
);

    localparam int FB = mswpg_pkg::FRAC_BITS;
    localparam int CB = mswpg_pkg::COORD_BITS;
    localparam int FW = mswpg_pkg::FACTOR_BITS;
    localparam int DB = mswpg_pkg::DIM_BITS;
    localparam int SB = mswpg_pkg::STRIDE_BITS;
    localparam int NB = mswpg_pkg::COUNT_BITS;
    localparam int QB = mswpg_pkg::DIV_BITS;
    localparam int PB = mswpg_pkg::PROD_BITS;
    localparam int KB = mswpg_pkg::SAMPLE_BITS;
    localparam int CNT_BITS = $clog2(QB);

    localparam logic [1:0] PH_PENDING = 2'd0;
    localparam logic [1:0] PH_RUN     = 2'd1;
    localparam logic [1:0] PH_DONE    = 2'd2;

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_DIVX    = 5'd1;
    localparam logic [4:0] S_DIVY_GO = 5'd2;
    localparam logic [4:0] S_DIVY    = 5'd3;
    localparam logic [4:0] S_MINF    = 5'd4;
    localparam logic [4:0] S_SK_NN   = 5'd5;
    localparam logic [4:0] S_SK_CHK  = 5'd6;
    localparam logic [4:0] S_SK_M1   = 5'd7;
    localparam logic [4:0] S_SK_M2   = 5'd8;
    localparam logic [4:0] S_SK_DGO  = 5'd9;
    localparam logic [4:0] S_SK_DIV  = 5'd10;
    localparam logic [4:0] S_SK_FAC  = 5'd11;
    localparam logic [4:0] S_SK_MW   = 5'd12;
    localparam logic [4:0] S_SK_MH   = 5'd13;
    localparam logic [4:0] S_SK_TEST = 5'd14;
    localparam logic [4:0] S_STEP    = 5'd15;
    localparam logic [4:0] S_EMIT    = 5'd16;

    // configuration
    logic [DB-1:0] iw_reg, ih_reg, ww_reg, wh_reg;
    logic [SB-1:0] stride_reg;
    logic [NB-1:0] count_reg;
    logic          mode_reg;

    // scan state
    logic [4:0]    state_reg;
    logic [1:0]    phase_reg;
    logic [NB-1:0] scale_reg;
    logic [CB-1:0] cur_x_reg, cur_y_reg, sw_reg, sh_reg;
    logic [FW-1:0] factor_reg, min_factor_reg;
    logic [KB-1:0] win_cnt_reg;

    // scale search
    logic [NB-1:0] seek_i_reg;
    logic          seek_start_reg;
    logic [DB-1:0] seek_div_reg;
    logic [FW-1:0] cand_reg, fx_reg;
    logic [CB-1:0] cand_w_reg;

    // shared multiplier and divider
    logic [QB-1:0] mul_a;
    logic [DB-1:0] mul_b;
    logic [PB-1:0] prod_reg;
    logic [QB-1:0] div_q_reg;
    logic [DB-1:0] div_r_reg, div_d_reg, div_r_next;
    logic [CNT_BITS-1:0] div_cnt_reg;
    logic [DB:0]   div_sh;
    logic          div_ge;
    logic          div_last;

    // result in work and output register
    logic          res_valid_reg, res_lis_reg, res_lo_reg;
    logic [mswpg_pkg::INDEX_BITS-1:0] res_scale_reg;
    logic [FW-1:0] res_factor_reg;
    logic [CB-1:0] res_x_reg, res_y_reg;
    logic [KB-1:0] res_sample_reg;
    logic          m_valid_reg;

    // derived values
    logic [DB-1:0] iw_nz, ih_nz;
    logic [SB-1:0] stride_nz;
    logic [NB-1:0] n_eff;
    logic [FW-1:0] span;
    logic [CB:0]   x_sum, y_sum;
    logic [CB:0]   x_gap, y_gap;
    logic          row_end, col_end;
    logic [CB-1:0] cand_h;
    logic          cand_ok;
    logic [NB:0]   seek_i_inc;

    always_comb begin
        iw_nz     = (iw_reg == '0) ? DB'(1) : iw_reg;
        ih_nz     = (ih_reg == '0) ? DB'(1) : ih_reg;
        stride_nz = (stride_reg == '0) ? SB'(1) : stride_reg;
        if (count_reg == '0) begin
            n_eff = NB'(1);
        end else if (count_reg > mswpg_pkg::MAX_SCALES) begin
            n_eff = mswpg_pkg::MAX_SCALES;
        end else begin
            n_eff = count_reg;
        end
        span = mswpg_pkg::FACTOR_CEIL - min_factor_reg;

        x_gap   = {1'b0, sw_reg} - (CB+1)'(ww_reg);
        y_gap   = {1'b0, sh_reg} - (CB+1)'(wh_reg);
        x_sum   = {1'b0, cur_x_reg} + (CB+1)'(stride_nz);
        y_sum   = {1'b0, cur_y_reg} + (CB+1)'(stride_nz);
        // a window grown past the scaled image never closes its row or column
        row_end = !x_gap[CB] && (x_sum > {1'b0, x_gap[CB-1:0]});
        col_end = !y_gap[CB] && (y_sum > {1'b0, y_gap[CB-1:0]});

        cand_h     = mswpg_pkg::sat_coord(prod_reg);
        cand_ok    = (cand_w_reg >= CB'(ww_reg)) && (cand_h >= CB'(wh_reg));
        seek_i_inc = {1'b0, seek_i_reg} + (NB+1)'(1);

        div_sh     = {div_r_reg, div_q_reg[QB-1]};
        div_ge     = div_sh >= {1'b0, div_d_reg};
        div_r_next = div_ge ? DB'(div_sh - {1'b0, div_d_reg}) : div_sh[DB-1:0];
        div_last   = div_cnt_reg == CNT_BITS'(QB - 1);
    end

    // operand select for the shared multiplier
    always_comb begin
        case (state_reg)
            S_SK_NN: begin
                mul_a = QB'(n_eff);
                mul_b = DB'(n_eff);
            end
            S_SK_M1: begin
                mul_a = QB'(span);
                mul_b = DB'(seek_i_reg);
            end
            S_SK_M2: begin
                mul_a = prod_reg[QB-1:0];
                mul_b = DB'(seek_i_reg);
            end
            S_SK_MW: begin
                mul_a = QB'(cand_reg);
                mul_b = iw_nz;
            end
            S_SK_MH: begin
                mul_a = QB'(cand_reg);
                mul_b = ih_nz;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        prod_reg <= PB'(mul_a) * PB'(mul_b);
    end

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            iw_reg     <= DB'(640);
            ih_reg     <= DB'(480);
            ww_reg     <= DB'(64);
            wh_reg     <= DB'(64);
            stride_reg <= SB'(8);
            count_reg  <= NB'(8);
            mode_reg   <= 1'b0;
        end else if (cfg_valid) begin
            case (cfg_index)
                mswpg_pkg::REG_IMAGE_WIDTH:   iw_reg     <= cfg_data;
                mswpg_pkg::REG_IMAGE_HEIGHT:  ih_reg     <= cfg_data;
                mswpg_pkg::REG_WINDOW_WIDTH:  ww_reg     <= cfg_data;
                mswpg_pkg::REG_WINDOW_HEIGHT: wh_reg     <= cfg_data;
                mswpg_pkg::REG_STRIDE:        stride_reg <= cfg_data[SB-1:0];
                mswpg_pkg::REG_SCALE_COUNT:   count_reg  <= cfg_data[NB-1:0];
                mswpg_pkg::REG_SPACING_MODE:  mode_reg   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // divider datapath: one quotient bit per cycle
    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: begin
                div_q_reg   <= QB'({ww_reg, {FB{1'b0}}});
                div_r_reg   <= '0;
                div_cnt_reg <= '0;
                div_d_reg   <= iw_nz;
            end
            S_DIVY_GO: begin
                div_q_reg   <= QB'({wh_reg, {FB{1'b0}}});
                div_r_reg   <= '0;
                div_cnt_reg <= '0;
                div_d_reg   <= ih_nz;
            end
            S_SK_DGO: begin
                div_q_reg   <= prod_reg[QB-1:0];
                div_r_reg   <= '0;
                div_cnt_reg <= '0;
                div_d_reg   <= seek_div_reg;
            end
            S_DIVX, S_DIVY, S_SK_DIV: begin
                div_q_reg   <= {div_q_reg[QB-2:0], div_ge};
                div_r_reg   <= div_r_next;
                div_cnt_reg <= div_cnt_reg + CNT_BITS'(1);
            end
            default: ;
        endcase
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            phase_reg      <= PH_PENDING;
            m_valid_reg    <= 1'b0;
            scale_reg      <= '0;
            cur_x_reg      <= '0;
            cur_y_reg      <= '0;
            sw_reg         <= '0;
            sh_reg         <= '0;
            factor_reg     <= '0;
            min_factor_reg <= '0;
            win_cnt_reg    <= '0;
            seek_start_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && state_reg != S_EMIT) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        if (s_restart || phase_reg == PH_PENDING) begin
                            state_reg <= S_DIVX;
                        end else if (phase_reg == PH_RUN) begin
                            state_reg <= S_STEP;
                        end else begin
                            res_valid_reg  <= 1'b0;
                            res_scale_reg  <= '0;
                            res_factor_reg <= '0;
                            res_x_reg      <= '0;
                            res_y_reg      <= '0;
                            res_sample_reg <= '0;
                            res_lis_reg    <= 1'b0;
                            res_lo_reg     <= 1'b0;
                            state_reg      <= S_EMIT;
                        end
                    end
                end
                S_DIVX: begin
                    if (div_last) begin
                        state_reg <= S_DIVY_GO;
                    end
                end
                S_DIVY_GO: begin
                    fx_reg    <= mswpg_pkg::sat_factor(div_q_reg);
                    state_reg <= S_DIVY;
                end
                S_DIVY: begin
                    if (div_last) begin
                        state_reg <= S_MINF;
                    end
                end
                S_MINF: begin
                    min_factor_reg <= (mswpg_pkg::sat_factor(div_q_reg) > fx_reg)
                                      ? mswpg_pkg::sat_factor(div_q_reg) : fx_reg;
                    win_cnt_reg    <= '0;
                    seek_i_reg     <= '0;
                    seek_start_reg <= 1'b1;
                    state_reg      <= S_SK_NN;
                end
                S_SK_NN: begin
                    state_reg <= S_SK_CHK;
                end
                S_SK_CHK: begin
                    seek_div_reg <= mode_reg ? prod_reg[DB-1:0] : DB'(n_eff);
                    if (seek_i_reg >= n_eff) begin
                        phase_reg <= PH_DONE;
                        if (seek_start_reg) begin
                            res_valid_reg  <= 1'b0;
                            res_scale_reg  <= '0;
                            res_factor_reg <= '0;
                            res_x_reg      <= '0;
                            res_y_reg      <= '0;
                            res_sample_reg <= '0;
                            res_lis_reg    <= 1'b0;
                            res_lo_reg     <= 1'b0;
                        end else begin
                            res_lo_reg <= 1'b1;
                        end
                        state_reg <= S_EMIT;
                    end else begin
                        state_reg <= S_SK_M1;
                    end
                end
                S_SK_M1: begin
                    state_reg <= mode_reg ? S_SK_M2 : S_SK_DGO;
                end
                S_SK_M2: begin
                    state_reg <= S_SK_DGO;
                end
                S_SK_DGO: begin
                    state_reg <= S_SK_DIV;
                end
                S_SK_DIV: begin
                    if (div_last) begin
                        state_reg <= S_SK_FAC;
                    end
                end
                S_SK_FAC: begin
                    cand_reg  <= min_factor_reg + div_q_reg[FW-1:0];
                    state_reg <= S_SK_MW;
                end
                S_SK_MW: begin
                    state_reg <= S_SK_MH;
                end
                S_SK_MH: begin
                    cand_w_reg <= mswpg_pkg::sat_coord(prod_reg);
                    state_reg  <= S_SK_TEST;
                end
                S_SK_TEST: begin
                    if (cand_ok) begin
                        scale_reg  <= seek_i_reg;
                        factor_reg <= cand_reg;
                        sw_reg     <= cand_w_reg;
                        sh_reg     <= cand_h;
                        cur_x_reg  <= '0;
                        cur_y_reg  <= '0;
                        phase_reg  <= PH_RUN;
                        state_reg  <= seek_start_reg ? S_STEP : S_EMIT;
                    end else begin
                        // try the next scale, n*n is formed again before the range check
                        seek_i_reg <= seek_i_inc[NB-1:0];
                        state_reg  <= S_SK_NN;
                    end
                end
                S_STEP: begin
                    res_valid_reg  <= 1'b1;
                    res_scale_reg  <= scale_reg[mswpg_pkg::INDEX_BITS-1:0];
                    res_factor_reg <= factor_reg;
                    res_x_reg      <= cur_x_reg;
                    res_y_reg      <= cur_y_reg;
                    res_sample_reg <= win_cnt_reg;
                    res_lis_reg    <= row_end && col_end;
                    res_lo_reg     <= 1'b0;
                    win_cnt_reg    <= win_cnt_reg + KB'(1);
                    if (!row_end) begin
                        cur_x_reg <= x_sum[CB-1:0];
                        state_reg <= S_EMIT;
                    end else if (!col_end) begin
                        cur_x_reg <= '0;
                        cur_y_reg <= y_sum[CB-1:0];
                        state_reg <= S_EMIT;
                    end else begin
                        seek_i_reg     <= scale_reg + NB'(1);
                        seek_start_reg <= 1'b0;
                        state_reg      <= S_SK_NN;
                    end
                end
                S_EMIT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        state_reg   <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // output payload register
    always_ff @(posedge aclk) begin
        if (state_reg == S_EMIT && (!m_valid_reg || m_ready)) begin
            m_valid_res     <= res_valid_reg;
            m_scale_index   <= res_scale_reg;
            m_scale_factor  <= res_factor_reg;
            m_pos_x         <= res_x_reg;
            m_pos_y         <= res_y_reg;
            m_sample_index  <= res_sample_reg;
            m_last_in_scale <= res_lis_reg;
            m_last_overall  <= res_lo_reg;
        end
    end

    assign s_ready   = state_reg == S_IDLE;
    assign m_valid   = m_valid_reg;
    assign cfg_ready = 1'b1;

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request transfer did not start the sequencer");

    a_last_overall_is_window: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_last_overall |-> m_valid_res && m_last_in_scale)
        else $error("final window of scan is not a final window of its scale");

    a_exhausted_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_valid_res |-> m_pos_x == '0 && m_pos_y == '0 &&
            m_sample_index == '0 && !m_last_in_scale && !m_last_overall)
        else $error("exhausted result carries nonzero fields");

    a_result_needs_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg) == S_EMIT)
        else $error("result raised outside the emit step");

endmodule

`default_nettype wire
